// File: design/rc4_multiround_stream_decrypt_unit_defines.svh
// Assertion macros shared by the RC4 decrypt unit checkers.
// Depends on a clock named clk in the scope that uses them.
`ifndef RC4_MULTIROUND_STREAM_DECRYPT_UNIT_DEFINES_SVH
`define RC4_MULTIROUND_STREAM_DECRYPT_UNIT_DEFINES_SVH

// Consequent checked in the cycle after the antecedent
`define RC4MS_ASSERT_NEXT(name, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same cycle as the antecedent
`define RC4MS_ASSERT_SAME(name, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/rc4ms_pkg.sv
// Shared constants and types for the RC4 multi-round stream decrypt unit.
// No dependencies; imported by the top level, its checker and the testbench.
package rc4ms_pkg;

  // Key store geometry
  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_CW    = $clog2(KEY_DEPTH + 1);

  // Configuration register indexes
  localparam logic REG_IV_LEN = 1'b0;
  localparam logic REG_ROUNDS = 1'b1;

  // Configuration reset values
  localparam logic [7:0] IV_LEN_RST = 8'd10;
  localparam logic [7:0] ROUNDS_RST = 8'd20;

  // Input opcodes; code 3 is unused
  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_CIPHER  = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

endpackage

// File: design/rc4_multiround_stream_decrypt_unit.sv
// A ciphertext byte passes through states KRI, KRJ, KW1, KW2, KRT and KOUT to its plain byte;
// no new item is taken until KOUT has registered it. Passphrase, IV and restart items do not stall.
// The first byte after the IV adds a table fill (FILL) plus the key schedule (SRD, SJ, SW1, SW2
// per swap, for every round), all set by the single port of the permutation table memory.
// Reset (synchronous): counters cleared, schedule flag dropped, IV length 10, rounds 20.
// The key store and permutation table are not cleared; the table is rebuilt per message.
module rc4_multiround_stream_decrypt_unit
  import rc4ms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] data_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] plain_byte
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SRD,
    ST_SJ,
    ST_SW1,
    ST_SW2,
    ST_KRI,
    ST_KRJ,
    ST_KW1,
    ST_KW2,
    ST_KRT,
    ST_KOUT
  } state_t;

  localparam logic [KEY_CW-1:0] KEY_FULL = KEY_CW'(KEY_DEPTH);

  state_t            state;
  logic [7:0]        iv_len;
  logic [7:0]        rounds;
  logic [KEY_CW-1:0] key_count;
  logic [7:0]        iv_count;
  logic [7:0]        stream_i;
  logic [7:0]        stream_j;
  logic              scheduled;
  logic [7:0]        n;
  logic [KEY_AW-1:0] k;
  logic [7:0]        r;
  logic [7:0]        si;
  logic [7:0]        tsum;
  logic [7:0]        cbyte;

  // permutation table, single port
  logic [7:0] perm_mem [256];
  logic [7:0] perm_rd;
  logic [7:0] perm_addr;
  logic [7:0] perm_wdata;
  logic       perm_we;
  logic       perm_re;

  // key store
  logic [7:0] key_mem [KEY_DEPTH];
  logic [7:0] key_rd;
  logic       key_we;
  logic       key_re;

  logic [7:0] kb;
  logic [7:0] j_add;
  logic       key_room;
  logic       iv_open;
  logic       k_wrap;

  assign in_stall = (state != ST_IDLE);
  assign key_room = (key_count != KEY_FULL);
  assign iv_open  = (iv_count < iv_len);
  assign k_wrap   = ((KEY_CW'(k) + KEY_CW'(1)) == key_count);

  // Shared index adder: key schedule adds the key byte, keystream adds zero
  assign kb    = (state == ST_SJ && key_count != '0) ? key_rd : 8'd0;
  assign j_add = stream_j + perm_rd + kb;

  // Append a key byte on a passphrase byte or an IV byte
  assign key_we = (state == ST_IDLE) && in_valid && !scheduled && key_room &&
                  ((opcode == OP_KEY) || (opcode == OP_CIPHER && iv_open));
  assign key_re = (state == ST_SRD);

  // Drive the permutation table port from the sequencer state
  always_comb begin
    perm_we    = 1'b0;
    perm_re    = 1'b0;
    perm_addr  = n;
    perm_wdata = perm_rd;
    unique case (state)
      ST_FILL: begin
        perm_we    = 1'b1;
        perm_wdata = n;
      end
      ST_SRD: perm_re = 1'b1;
      ST_SJ, ST_KRJ: begin
        perm_re   = 1'b1;
        perm_addr = j_add;
      end
      ST_SW1: perm_we = 1'b1;
      ST_SW2, ST_KW2: begin
        perm_we    = 1'b1;
        perm_addr  = stream_j;
        perm_wdata = si;
      end
      ST_KRI: begin
        perm_re   = 1'b1;
        perm_addr = stream_i + 8'd1;
      end
      ST_KW1: begin
        perm_we   = 1'b1;
        perm_addr = stream_i;
      end
      ST_KRT: begin
        perm_re   = 1'b1;
        perm_addr = tsum;
      end
      default: ;
    endcase
  end

  // Permutation table memory
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_addr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rd <= perm_mem[perm_addr];
    end
  end

  // Key store memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count[KEY_AW-1:0]] <= data_byte;
    end
    if (key_re) begin
      key_rd <= key_mem[k];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iv_len <= IV_LEN_RST;
      rounds <= ROUNDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IV_LEN: iv_len <= cfg_data;
        REG_ROUNDS: rounds <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key_count <= '0;
      iv_count  <= '0;
      stream_i  <= '0;
      stream_j  <= '0;
      scheduled <= 1'b0;
      n         <= '0;
      k         <= '0;
      r         <= '0;
      out_valid <= 1'b0;
    end else begin
      // raise a new result, or drop the held one once transferred
      if (state == ST_KOUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (opcode)
              OP_KEY: begin
                if (key_we) begin
                  key_count <= key_count + KEY_CW'(1);
                end
              end
              OP_RESTART: begin
                key_count <= '0;
                iv_count  <= '0;
                stream_i  <= '0;
                stream_j  <= '0;
                scheduled <= 1'b0;
              end
              OP_CIPHER: begin
                cbyte <= data_byte;
                if (scheduled) begin
                  state <= ST_KRI;
                end else if (iv_open) begin
                  if (key_room) begin
                    key_count <= key_count + KEY_CW'(1);
                  end
                  iv_count <= iv_count + 8'd1;
                end else begin
                  n     <= '0;
                  state <= ST_FILL;
                end
              end
              default: ;
            endcase
          end
        end
        // rebuild identity table
        ST_FILL: begin
          n <= n + 8'd1;
          if (n == 8'hFF) begin
            stream_j <= '0;
            r        <= '0;
            k        <= '0;
            if (rounds == 8'd0) begin
              stream_i  <= '0;
              scheduled <= 1'b1;
              state     <= ST_KRI;
            end else begin
              state <= ST_SRD;
            end
          end
        end
        ST_SRD: state <= ST_SJ;
        ST_SJ: begin
          si       <= perm_rd;
          stream_j <= j_add;
          state    <= ST_SW1;
        end
        ST_SW1: state <= ST_SW2;
        // finish the swap and advance the schedule counters
        ST_SW2: begin
          n     <= n + 8'd1;
          k     <= k_wrap ? '0 : k + KEY_AW'(1);
          state <= ST_SRD;
          if (n == 8'hFF) begin
            k <= '0;
            if (r == rounds - 8'd1) begin
              stream_i  <= '0;
              stream_j  <= '0;
              scheduled <= 1'b1;
              state     <= ST_KRI;
            end else begin
              r <= r + 8'd1;
            end
          end
        end
        ST_KRI: begin
          stream_i <= stream_i + 8'd1;
          state    <= ST_KRJ;
        end
        ST_KRJ: begin
          si       <= perm_rd;
          stream_j <= j_add;
          state    <= ST_KW1;
        end
        ST_KW1: begin
          tsum  <= si + perm_rd;
          state <= ST_KW2;
        end
        ST_KW2: state <= ST_KRT;
        ST_KRT: state <= ST_KOUT;
        // hold until the output register is free
        ST_KOUT: begin
          if (!out_valid || !out_stall) begin
            plain_byte <= cbyte ^ perm_rd;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/rc4ms_checker.sv
// Port-level checker for the RC4 multi-round stream decrypt unit, bound to the top level.
// Depends on rc4ms_pkg and the assertion macros header.
`include "rc4_multiround_stream_decrypt_unit_defines.svh"

module rc4ms_checker
  import rc4ms_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] opcode,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] plain_byte
);

  // A stalled result stays and keeps its value
  `RC4MS_ASSERT_NEXT(a_out_hold, rst, out_valid && out_stall, out_valid && $stable(plain_byte), "stalled result changed")

  // Only ciphertext transfers occupy the block
  `RC4MS_ASSERT_NEXT(a_quick_ops, rst, in_valid && !in_stall && opcode != OP_CIPHER, !in_stall, "non-ciphertext item stalled input")

  // A new result follows decryption work, never an idle cycle
  `RC4MS_ASSERT_SAME(a_out_from_work, rst, $rose(out_valid), $past(in_stall), "result appeared without work")

  // Reset leaves no result pending
  `RC4MS_ASSERT_NEXT(a_reset_clear, 1'b0, rst, !out_valid && !in_stall, "reset left output or stall set")

endmodule

bind rc4_multiround_stream_decrypt_unit rc4ms_checker u_rc4ms_checker (.*);

// File: sim/tb_top.sv
// Testbench for rc4_multiround_stream_decrypt_unit: drives passphrase, IV, ciphertext
// and restart transfers and checks every plain byte against an RC4 keystream predictor.
// Depends on rc4ms_pkg and the unit's RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rc4ms_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1200;
  localparam int SETTLE_CYCLES = 16;

  // Mirror of the decryptor: key schedule, keystream and the queue of plain bytes due
  class rc4_plain_scoreboard;
    logic [7:0] iv_len;
    logic [7:0] round_cnt;
    logic [7:0] sbox [256];
    logic [7:0] key_bytes [KEY_DEPTH];
    int unsigned key_len;
    int unsigned iv_taken;
    logic [7:0] ks_i;
    logic [7:0] ks_j;
    bit keyed;
    logic [7:0] plain_expected [$];
    int unsigned error_count;

    function new();
      iv_len = IV_LEN_RST;
      round_cnt = ROUNDS_RST;
      for (int n = 0; n < 256; n++) sbox[n] = n[7:0];
      clear_message();
      error_count = 0;
    endfunction

    function void clear_message();
      key_len = 0;
      iv_taken = 0;
      ks_i = 8'd0;
      ks_j = 8'd0;
      keyed = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [7:0] value);
      if (idx == REG_IV_LEN) begin
        iv_len = value;
      end else begin
        round_cnt = value;
      end
    endfunction

    // Drop key bytes once the store is full
    function void append_key(logic [7:0] b);
      if (key_len < KEY_DEPTH) begin
        key_bytes[key_len] = b;
        key_len++;
      end
    endfunction

    // Rebuild the table and repeat the swap loop, carrying j across rounds
    function void run_key_schedule();
      logic [7:0] j;
      logic [7:0] kb;
      logic [7:0] t;
      j = 8'd0;
      for (int n = 0; n < 256; n++) sbox[n] = n[7:0];
      for (int r = 0; r < round_cnt; r++) begin
        for (int n = 0; n < 256; n++) begin
          kb = (key_len != 0) ? key_bytes[n % key_len] : 8'h00;
          j = j + sbox[n] + kb;
          t = sbox[n];
          sbox[n] = sbox[j];
          sbox[j] = t;
        end
      end
      ks_i = 8'd0;
      ks_j = 8'd0;
      keyed = 1'b1;
    endfunction

    function logic [7:0] next_keystream_byte();
      logic [7:0] t;
      logic [7:0] idx;
      ks_i = ks_i + 8'd1;
      ks_j = ks_j + sbox[ks_i];
      t = sbox[ks_i];
      sbox[ks_i] = sbox[ks_j];
      sbox[ks_j] = t;
      idx = sbox[ks_i] + sbox[ks_j];
      return sbox[idx];
    endfunction

    // Advance the mirror by one accepted input transfer
    function void note_transfer(logic [1:0] op, logic [7:0] b);
      case (op)
        OP_KEY: begin
          if (!keyed) append_key(b);
        end
        OP_RESTART: begin
          clear_message();
        end
        OP_CIPHER: begin
          if (!keyed && iv_taken < iv_len) begin
            append_key(b);
            iv_taken++;
          end else begin
            if (!keyed) run_key_schedule();
            plain_expected.insert(plain_expected.size(), b ^ next_keystream_byte());
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      error_count++;
      $display("[%0t] plain byte check failed: %s", $time, msg);
    endtask

    task check_plain(logic [7:0] got);
      logic [7:0] want;
      if (plain_expected.size() == 0) begin
        report_mismatch($sformatf("got %02h with nothing expected", got));
      end else begin
        want = plain_expected.pop_front();
        if (got !== want) report_mismatch($sformatf("got %02h, expected %02h", got, want));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] plain_byte;

  rc4_plain_scoreboard sb;
  bit calm;
  int unsigned items_sent;

  rc4_multiround_stream_decrypt_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .plain_byte (plain_byte)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check each output transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_plain(plain_byte);
    out_stall <= !calm && ($urandom_range(99) < 9);
  end

  // Hold one input transfer until accepted, with an occasional idle gap ahead of it
  task automatic send_item(logic [1:0] op, logic [7:0] b);
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_UNUSED && !(op == OP_KEY && sb.keyed)) items_sent++;
    sb.note_transfer(op, b);
  endtask

  // Wait until every plain byte due has arrived and the unit has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.plain_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // One message: optional restart, passphrase, IV (maybe cut short), then ciphertext if the IV was not cut
  task automatic send_message(bit restart_first, int unsigned key_n, int unsigned cipher_n,
                              bit cut_iv);
    int unsigned iv_n;
    iv_n = sb.iv_len;
    if (cut_iv && iv_n > 0) iv_n = $urandom_range(iv_n - 1);
    if (restart_first) send_item(OP_RESTART, 8'($urandom));
    repeat (key_n) send_item(OP_KEY, 8'($urandom));
    repeat (iv_n) begin
      if ($urandom_range(99) < 10) send_item(OP_KEY, 8'($urandom));
      send_item(OP_CIPHER, 8'($urandom));
    end
    if (!cut_iv) begin
      repeat (cipher_n) begin
        if ($urandom_range(99) < 6)
          send_item(($urandom_range(1) != 0) ? OP_UNUSED : 2'(OP_KEY), 8'($urandom));
        send_item(OP_CIPHER, 8'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned key_n;
    sb = new();
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_KEY;
    data_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_index = REG_IV_LEN;
    cfg_data = 8'h00;
    out_stall = 1'b0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: extreme key bytes, unused opcode, key byte between IV bytes
    send_item(OP_KEY, 8'h00);
    send_item(OP_KEY, 8'hFF);
    send_item(OP_UNUSED, 8'h3C);
    send_item(OP_CIPHER, 8'h00);
    send_item(OP_CIPHER, 8'hFF);
    send_item(OP_KEY, 8'h55);
    send_item(OP_CIPHER, 8'h80);
    send_item(OP_CIPHER, 8'h01);
    send_item(OP_CIPHER, 8'h7F);
    drain();

    // Shorten the IV below what was already taken: next ciphertext starts the schedule
    write_reg(REG_IV_LEN, 8'd3);
    send_item(OP_CIPHER, 8'h00);
    send_item(OP_CIPHER, 8'hFF);
    send_item(OP_CIPHER, 8'hA5);
    send_item(OP_KEY, 8'h12);
    send_item(OP_UNUSED, 8'hC0);
    send_item(OP_CIPHER, 8'h5A);
    drain();

    // Empty key, no IV
    write_reg(REG_IV_LEN, 8'd0);
    write_reg(REG_ROUNDS, 8'd1);
    send_item(OP_RESTART, 8'hFF);
    send_item(OP_CIPHER, 8'hFF);
    send_item(OP_CIPHER, 8'h00);
    drain();

    // Zero rounds leave the table at identity
    write_reg(REG_ROUNDS, 8'd0);
    send_item(OP_RESTART, 8'h00);
    send_item(OP_KEY, 8'hC3);
    send_item(OP_CIPHER, 8'h00);
    send_item(OP_CIPHER, 8'h11);
    drain();

    // Random phases: fresh settings, three messages each, one phase without idling
    items_sent = 0;
    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      calm <= (phase == 2);
      write_reg(REG_IV_LEN,
                8'(($urandom_range(99) < 80) ? $urandom_range(12) : $urandom_range(13, 64)));
      write_reg(REG_ROUNDS,
                8'(($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(4, 24)));
      for (int m = 0; m < 3; m++) begin
        pick = $urandom_range(99);
        if (pick < 2) key_n = $urandom_range(257, 300);
        else if (pick < 12) key_n = $urandom_range(17, 64);
        else key_n = $urandom_range(16);
        send_message($urandom_range(99) < 85, key_n, $urandom_range(4, 30),
                     m == 2 && $urandom_range(99) < 15);
      end
      drain();
    end

    // Longest IV and most rounds; passphrase plus IV overflows the key store
    calm <= 1'b0;
    write_reg(REG_IV_LEN, 8'd255);
    write_reg(REG_ROUNDS, 8'd255);
    send_message(1'b1, 3, 4, 1'b0);
    drain();

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #500_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
